>>> hw/rtl/swarq_pkg.sv
package swarq_pkg;

  localparam int unsigned MAX_OUT = 8;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] RKIND_NEW     = 2'd0;
  localparam logic [1:0] RKIND_RESEND  = 2'd1;
  localparam logic [1:0] RKIND_REFUSED = 2'd2;

  localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;

  localparam logic [3:0]  WINDOW_SIZE_RST   = 4'd8;
  localparam logic [23:0] TIMEOUT_TICKS_RST = 24'd1000;
  localparam logic [31:0] SEQ_RST           = 32'd1;

endpackage

>>> hw/rtl/swarq_ram.sv
module swarq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sliding_window_arq_sender.sv
// Sliding-window ARQ sender. An item is taken when start is high and busy is low;
// kind_i selects send, ack or tick, the other input ports carry its fields.
// Results leave on the result ports, one per cycle, each marked by strobe_o
// for exactly one cycle; last_o flags the final result of an item.
// The receiver cannot stall, so results are never held back.
// A send passes through ST_SEND and gives one result, registered from that
// state; the block is busy only in ST_SEND. A valid ack goes through ST_ACK,
// then ST_ADV, which moves the base over acked slots one slot a cycle (at
// most 8), and gives no result; an ack failing the checksum or window test
// goes from ST_ACK straight back to idle. A tick is busy in ST_TICK, and on
// expiry also in ST_RESEND while the unacked packets are resent (at most
// 8); resends stream one per cycle from the checksum RAM, the checksum
// leaving it in the cycle after the slot pick. No new item is taken until
// the last is done; the resend walk and base advance set the worst case.
// The configuration channel (cfg_valid_i/cfg_ready_o) writes window_size
// (index 0) and timeout_ticks (index 1); it is ready whenever not busy.
// Reset puts base and next sequence at 1, clears acked marks, stops the
// timer and loads window_size 8 and timeout_ticks 1000. The checksum RAM
// is not cleared: each slot is written before it can be resent.
module sliding_window_arq_sender #(
  parameter int unsigned WINDOW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic signed [12:0] payload_sum_i,
  input  logic signed [31:0] ack_seq_field_i,
  input  logic signed [31:0] ack_number_i,
  input  logic signed [31:0] ack_check_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output logic               strobe_o,
  output logic [1:0]         result_kind_o,
  output logic signed [31:0] packet_seq_o,
  output logic signed [31:0] packet_check_o,
  output logic [2:0]         buffer_slot_o,
  output logic signed [31:0] window_base_o,
  output logic               last_o
);

  localparam int unsigned SW   = $clog2(WINDOW);
  localparam int unsigned ADDW = ((SW > 4) ? SW : 4) + 1;
  localparam int unsigned WLIM = (WINDOW < swarq_pkg::MAX_OUT) ? WINDOW : swarq_pkg::MAX_OUT;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_ACK,
    ST_ADV,
    ST_TICK,
    ST_RESEND
  } state_e;

  function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] s, input logic [3:0] k);
    logic [ADDW-1:0] sum;
    sum = ADDW'(s) + ADDW'(k);
    if (sum >= ADDW'(WINDOW)) begin
      sum = sum - ADDW'(WINDOW);
    end
    return sum[SW-1:0];
  endfunction

  function automatic logic [2:0] slot3(input logic [SW-1:0] s);
    logic [SW+2:0] ext;
    ext = {3'b000, s};
    return ext[2:0];
  endfunction

  state_e state_q, state_d;

  logic [3:0]        win_size_q, win_size_d;
  logic [23:0]       timeout_q, timeout_d;
  logic [31:0]       base_seq_q, base_seq_d;
  logic [31:0]       next_seq_q, next_seq_d;
  logic [SW-1:0]     base_slot_q, base_slot_d;
  logic [SW-1:0]     next_slot_q, next_slot_d;
  logic [3:0]        count_q, count_d;
  logic [WINDOW-1:0] acked_q, acked_d;
  logic              running_q, running_d;
  logic [23:0]       left_q, left_d;
  logic              moved_q, moved_d;
  logic [7:0]        mask_q, mask_d;

  logic [12:0] psum_q, psum_d;
  logic [31:0] aseq_q, aseq_d;
  logic [31:0] anum_q, anum_d;
  logic [31:0] acheck_q, acheck_d;

  logic        strobe_q, strobe_d;
  logic        use_ram_q, use_ram_d;
  logic [1:0]  rkind_q, rkind_d;
  logic [31:0] rseq_q, rseq_d;
  logic [31:0] rcheck_q, rcheck_d;
  logic [2:0]  rslot_q, rslot_d;
  logic [31:0] rbase_q, rbase_d;
  logic        rlast_q, rlast_d;

  logic          ram_we, ram_re;
  logic [SW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [31:0]   psum_ext, check_new, ack_sum, ack_off;
  logic          ack_ok;
  logic [SW-1:0] ack_slot;
  logic [3:0]    eff_win;
  logic [7:0]    exp_mask, pick_rest;
  logic [2:0]    pick_k;
  logic [SW-1:0] pick_slot;

  assign psum_ext  = {{19{psum_q[12]}}, psum_q};
  assign check_new = next_seq_q + psum_ext;
  assign ack_sum   = aseq_q + anum_q + psum_ext;
  assign ack_off   = anum_q - base_seq_q;
  assign ack_ok    = (ack_sum == acheck_q) && (ack_off < {28'd0, count_q});
  assign ack_slot  = slot_add(base_slot_q, ack_off[3:0]);

  always_comb begin
    if (win_size_q == 4'd0) begin
      eff_win = 4'd1;
    end else if (win_size_q > 4'(WLIM)) begin
      eff_win = 4'(WLIM);
    end else begin
      eff_win = win_size_q;
    end
  end

  always_comb begin
    logic [SW-1:0] idx;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < count_q) begin
        idx         = slot_add(base_slot_q, 4'(k));
        exp_mask[k] = ~acked_q[idx];
      end else begin
        idx         = '0;
        exp_mask[k] = 1'b0;
      end
    end
  end

  always_comb begin
    pick_k = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (mask_q[k]) begin
        pick_k = 3'(k);
      end
    end
  end

  assign pick_rest = mask_q & ~(8'd1 << pick_k);
  assign pick_slot = slot_add(base_slot_q, {1'b0, pick_k});
  assign ram_raddr = pick_slot;

  always_comb begin
    state_d     = state_q;
    win_size_d  = win_size_q;
    timeout_d   = timeout_q;
    base_seq_d  = base_seq_q;
    next_seq_d  = next_seq_q;
    base_slot_d = base_slot_q;
    next_slot_d = next_slot_q;
    count_d     = count_q;
    acked_d     = acked_q;
    running_d   = running_q;
    left_d      = left_q;
    moved_d     = moved_q;
    mask_d      = mask_q;
    psum_d      = psum_q;
    aseq_d      = aseq_q;
    anum_d      = anum_q;
    acheck_d    = acheck_q;
    strobe_d    = 1'b0;
    use_ram_d   = 1'b0;
    rkind_d     = rkind_q;
    rseq_d      = rseq_q;
    rcheck_d    = rcheck_q;
    rslot_d     = rslot_q;
    rbase_d     = rbase_q;
    rlast_d     = rlast_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        swarq_pkg::CFG_WINDOW_SIZE:   win_size_d = cfg_data_i[3:0];
        swarq_pkg::CFG_TIMEOUT_TICKS: timeout_d  = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          psum_d   = payload_sum_i;
          aseq_d   = ack_seq_field_i;
          anum_d   = ack_number_i;
          acheck_d = ack_check_i;
          case (kind_i)
            swarq_pkg::KIND_SEND: state_d = ST_SEND;
            swarq_pkg::KIND_ACK:  state_d = ST_ACK;
            swarq_pkg::KIND_TICK: state_d = ST_TICK;
            default:              state_d = ST_IDLE;
          endcase
        end
      end
      ST_SEND: begin
        strobe_d = 1'b1;
        rbase_d  = base_seq_q;
        rlast_d  = 1'b1;
        if (count_q < eff_win) begin
          ram_we               = 1'b1;
          acked_d[next_slot_q] = 1'b0;
          if (count_q == 4'd0) begin
            running_d = 1'b1;
            left_d    = timeout_q;
          end
          next_seq_d  = next_seq_q + 32'd1;
          next_slot_d = slot_add(next_slot_q, 4'd1);
          count_d     = count_q + 4'd1;
          rkind_d     = swarq_pkg::RKIND_NEW;
          rseq_d      = next_seq_q;
          rcheck_d    = check_new;
          rslot_d     = slot3(next_slot_q);
        end else begin
          rkind_d  = swarq_pkg::RKIND_REFUSED;
          rseq_d   = '0;
          rcheck_d = '0;
          rslot_d  = '0;
        end
        state_d = ST_IDLE;
      end
      ST_ACK: begin
        moved_d = 1'b0;
        if (ack_ok) begin
          acked_d[ack_slot] = 1'b1;
          state_d           = ST_ADV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ADV: begin
        if (count_q != 4'd0 && acked_q[base_slot_q]) begin
          base_seq_d  = base_seq_q + 32'd1;
          base_slot_d = slot_add(base_slot_q, 4'd1);
          count_d     = count_q - 4'd1;
          moved_d     = 1'b1;
        end else begin
          if (count_q == 4'd0) begin
            running_d = 1'b0;
            left_d    = '0;
          end else if (moved_q) begin
            running_d = 1'b1;
            left_d    = timeout_q;
          end
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        state_d = ST_IDLE;
        if (running_q) begin
          if (left_q > 24'd1) begin
            left_d = left_q - 24'd1;
          end else begin
            mask_d = exp_mask;
            if (count_q != 4'd0) begin
              left_d = timeout_q;
            end else begin
              running_d = 1'b0;
              left_d    = '0;
            end
            if (exp_mask != 8'd0) begin
              state_d = ST_RESEND;
            end
          end
        end
      end
      ST_RESEND: begin
        ram_re    = 1'b1;
        strobe_d  = 1'b1;
        use_ram_d = 1'b1;
        rkind_d   = swarq_pkg::RKIND_RESEND;
        rseq_d    = base_seq_q + {29'd0, pick_k};
        rslot_d   = slot3(pick_slot);
        rbase_d   = base_seq_q;
        rlast_d   = (pick_rest == 8'd0);
        mask_d    = pick_rest;
        if (pick_rest == 8'd0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_size_q  <= swarq_pkg::WINDOW_SIZE_RST;
      timeout_q   <= swarq_pkg::TIMEOUT_TICKS_RST;
      base_seq_q  <= swarq_pkg::SEQ_RST;
      next_seq_q  <= swarq_pkg::SEQ_RST;
      base_slot_q <= SW'(1);
      next_slot_q <= SW'(1);
      count_q     <= '0;
      acked_q     <= '0;
      running_q   <= 1'b0;
      left_q      <= '0;
      moved_q     <= 1'b0;
      mask_q      <= '0;
      strobe_q    <= 1'b0;
      use_ram_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_size_q  <= win_size_d;
      timeout_q   <= timeout_d;
      base_seq_q  <= base_seq_d;
      next_seq_q  <= next_seq_d;
      base_slot_q <= base_slot_d;
      next_slot_q <= next_slot_d;
      count_q     <= count_d;
      acked_q     <= acked_d;
      running_q   <= running_d;
      left_q      <= left_d;
      moved_q     <= moved_d;
      mask_q      <= mask_d;
      strobe_q    <= strobe_d;
      use_ram_q   <= use_ram_d;
    end
  end

  always_ff @(posedge clk_i) begin
    psum_q   <= psum_d;
    aseq_q   <= aseq_d;
    anum_q   <= anum_d;
    acheck_q <= acheck_d;
    rkind_q  <= rkind_d;
    rseq_q   <= rseq_d;
    rcheck_q <= rcheck_d;
    rslot_q  <= rslot_d;
    rbase_q  <= rbase_d;
    rlast_q  <= rlast_d;
  end

  swarq_ram #(
    .WIDTH(32),
    .DEPTH(WINDOW)
  ) u_check_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(next_slot_q),
    .wdata_i(check_new),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = ~busy;
  assign strobe_o       = strobe_q;
  assign result_kind_o  = rkind_q;
  assign packet_seq_o   = rseq_q;
  assign packet_check_o = use_ram_q ? ram_rdata : rcheck_q;
  assign buffer_slot_o  = rslot_q;
  assign window_base_o  = rbase_q;
  assign last_o         = rlast_q;

  // outstanding count tracks the sequence span
  a_count_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_seq_q - base_seq_q) == {28'd0, count_q})
    else $error("outstanding count out of step with sequence span");

  a_count_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 4'(WLIM))
    else $error("outstanding count above window limit");

  a_timer_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && running_q) |-> (count_q != 4'd0))
    else $error("timer running with empty window");

  a_ram_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    use_ram_q |-> (strobe_q && rkind_q == swarq_pkg::RKIND_RESEND))
    else $error("checksum RAM data used outside a resend item");

endmodule

>>> verif/sliding_window_arq_sender_test.sv
`timescale 1ns / 100ps

localparam int unsigned WIN = 8;
localparam logic [1:0] KIND_NONE = 2'd3;

typedef struct packed {
  logic [1:0]  rkind;
  logic [31:0] seq;
  logic [31:0] check;
  logic [2:0]  slot;
  logic [31:0] base;
  logic        last;
} packet_t;

class arq_scoreboard;
  logic [3:0]  window_size;
  logic [23:0] timeout_ticks;
  logic [31:0] base_seq;
  logic [31:0] next_seq;
  logic [31:0] slot_check [WIN];
  bit          slot_acked [WIN];
  bit          timer_on;
  logic [23:0] timer_left;
  packet_t     pending [$];
  int          errors;

  function new();
    window_size   = swarq_pkg::WINDOW_SIZE_RST;
    timeout_ticks = swarq_pkg::TIMEOUT_TICKS_RST;
    base_seq      = swarq_pkg::SEQ_RST;
    next_seq      = swarq_pkg::SEQ_RST;
    foreach (slot_acked[i]) slot_acked[i] = 1'b0;
    timer_on      = 1'b0;
    timer_left    = '0;
    errors        = 0;
  endfunction

  task report(string what);
    $display("%0t: mismatch: %s", $time, what);
    errors++;
  endtask

  function void write_reg(logic [1:0] idx, logic [23:0] data);
    if (idx == swarq_pkg::CFG_WINDOW_SIZE) window_size = data[3:0];
    else if (idx == swarq_pkg::CFG_TIMEOUT_TICKS) timeout_ticks = data;
  endfunction

  function int unsigned eff_window();
    int unsigned lim;
    int unsigned w;
    lim = (WIN < swarq_pkg::MAX_OUT) ? WIN : swarq_pkg::MAX_OUT;
    w = window_size;
    if (w < 1) w = 1;
    if (w > lim) w = lim;
    return w;
  endfunction

  function void restart_timer();
    timer_on   = 1'b1;
    timer_left = timeout_ticks;
  endfunction

  // Works out the packets an accepted item puts on the link.
  function void note_item(logic [1:0] k, logic [12:0] ps, logic [31:0] aseq,
                          logic [31:0] anum, logic [31:0] acheck);
    logic [31:0] psum;
    logic [31:0] span;
    logic [31:0] seq;
    int unsigned slot;
    int unsigned count;
    int          guard;
    int          n;
    bit          moved;
    psum = {{19{ps[12]}}, ps};
    span = next_seq - base_seq;
    case (k)
      swarq_pkg::KIND_SEND: begin
        if (span < eff_window()) begin
          seq = next_seq;
          slot = seq % WIN;
          slot_check[slot] = seq + psum;
          slot_acked[slot] = 1'b0;
          if (span == 0) restart_timer();
          next_seq = seq + 1;
          pending.push_back(packet_t'{swarq_pkg::RKIND_NEW, seq, slot_check[slot],
                                      slot[2:0], base_seq, 1'b1});
        end else begin
          pending.push_back(packet_t'{swarq_pkg::RKIND_REFUSED, '0, '0, '0,
                                      base_seq, 1'b1});
        end
      end
      swarq_pkg::KIND_ACK: begin
        if (aseq + anum + psum == acheck && anum - base_seq < span) begin
          moved = 1'b0;
          slot_acked[anum % WIN] = 1'b1;
          for (guard = 0; guard < swarq_pkg::MAX_OUT && base_seq != next_seq &&
               slot_acked[base_seq % WIN]; guard++) begin
            base_seq++;
            moved = 1'b1;
          end
          if (base_seq == next_seq) begin
            timer_on   = 1'b0;
            timer_left = '0;
          end else if (moved) begin
            restart_timer();
          end
        end
      end
      swarq_pkg::KIND_TICK: begin
        if (!timer_on) return;
        if (timer_left > 1) begin
          timer_left--;
          return;
        end
        count = (span > swarq_pkg::MAX_OUT) ? swarq_pkg::MAX_OUT : span;
        n = 0;
        for (int unsigned i = 0; i < count; i++) begin
          seq = base_seq + i;
          slot = seq % WIN;
          if (!slot_acked[slot]) begin
            pending.push_back(packet_t'{swarq_pkg::RKIND_RESEND, seq, slot_check[slot],
                                        slot[2:0], base_seq, 1'b0});
            n++;
          end
        end
        if (n > 0) pending[pending.size() - 1].last = 1'b1;
        if (next_seq != base_seq) restart_timer();
        else begin
          timer_on   = 1'b0;
          timer_left = '0;
        end
      end
      default: ;
    endcase
  endfunction

  task check_result(packet_t got);
    packet_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected packet kind %0d seq %0d", got.rkind, got.seq));
      return;
    end
    want = pending.pop_front();
    if (got.rkind !== want.rkind)
      report($sformatf("result_kind got %0d exp %0d", got.rkind, want.rkind));
    if (got.seq !== want.seq)
      report($sformatf("packet_seq got %h exp %h", got.seq, want.seq));
    if (got.check !== want.check)
      report($sformatf("packet_check got %h exp %h", got.check, want.check));
    if (got.slot !== want.slot)
      report($sformatf("buffer_slot got %0d exp %0d", got.slot, want.slot));
    if (got.base !== want.base)
      report($sformatf("window_base got %h exp %h", got.base, want.base));
    if (got.last !== want.last)
      report($sformatf("last got %b exp %b", got.last, want.last));
  endtask
endclass

module sliding_window_arq_sender_test;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind_i = swarq_pkg::KIND_TICK;
  logic signed [12:0] payload_sum_i = '0;
  logic signed [31:0] ack_seq_field_i = '0;
  logic signed [31:0] ack_number_i = '0;
  logic signed [31:0] ack_check_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = swarq_pkg::CFG_WINDOW_SIZE;
  logic [23:0]        cfg_data_i = '0;
  logic               strobe_o;
  logic [1:0]         result_kind_o;
  logic signed [31:0] packet_seq_o;
  logic signed [31:0] packet_check_o;
  logic [2:0]         buffer_slot_o;
  logic signed [31:0] window_base_o;
  logic               last_o;

  arq_scoreboard sb = new();
  bit idle_en = 1'b1;

  logic [3:0]  phase_win [8] = '{4'd8, 4'd1, 4'd15, 4'd4, 4'd0, 4'd3, 4'd2, 4'd8};
  logic [23:0] phase_tmo [8] = '{24'd3, 24'd1, 24'd2, 24'd6, 24'hFFFFFF, 24'd2, 24'd5, 24'd4};

  sliding_window_arq_sender uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o)
      sb.check_result(packet_t'{result_kind_o, packet_seq_o, packet_check_o, buffer_slot_o,
                                window_base_o, last_o});
  end

  // Returns at the edge that takes the item; the caller drives again in that step.
  task automatic drive_item(input logic [1:0] k, input logic [12:0] ps,
                            input logic [31:0] aseq, input logic [31:0] anum,
                            input logic [31:0] acheck);
    if (idle_en && $urandom_range(99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start           <= 1'b1;
    kind_i          <= k;
    payload_sum_i   <= ps;
    ack_seq_field_i <= aseq;
    ack_number_i    <= anum;
    ack_check_i     <= acheck;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(k, ps, aseq, anum, acheck);
  endtask

  task automatic send_ack(input logic [31:0] anum, input bit corrupt);
    logic [31:0] aseq;
    logic [12:0] ps;
    logic [31:0] sum;
    aseq = $urandom;
    ps   = 13'($urandom);
    sum  = aseq + anum + {{19{ps[12]}}, ps};
    if (corrupt) sum = sum ^ (32'd1 << $urandom_range(31));
    drive_item(swarq_pkg::KIND_ACK, ps, aseq, anum, sum);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [3:0] w, input logic [23:0] t);
    cfg_write(swarq_pkg::CFG_WINDOW_SIZE, {20'($urandom), w});
    cfg_write(swarq_pkg::CFG_TIMEOUT_TICKS, t);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int          pick;
    logic [31:0] span;
    repeat (n) begin
      pick = $urandom_range(99);
      span = sb.next_seq - sb.base_seq;
      if (pick < 40) begin
        drive_item(swarq_pkg::KIND_SEND, 13'($urandom), $urandom, $urandom, $urandom);
      end else if (pick < 72) begin
        if (span != 0 && $urandom_range(4) != 0)
          send_ack(sb.base_seq + $urandom_range(span - 1), 1'b0);
        else begin
          case ($urandom_range(2))
            0: send_ack(sb.base_seq + $urandom_range(span), 1'b1);
            1: send_ack($urandom_range(1) ? sb.next_seq + $urandom_range(3)
                                          : sb.base_seq - 1 - $urandom_range(3), 1'b0);
            default: drive_item(swarq_pkg::KIND_ACK, 13'($urandom), $urandom, $urandom,
                                $urandom);
          endcase
        end
      end else if (pick < 97) begin
        drive_item(swarq_pkg::KIND_TICK, 13'($urandom), $urandom, $urandom, $urandom);
      end else begin
        drive_item(KIND_NONE, 13'($urandom), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window 8, long timeout
    drive_item(swarq_pkg::KIND_TICK, '0, '0, '0, '0);          // timer stopped
    drive_item(swarq_pkg::KIND_SEND, 13'h0FFF, '0, '0, '0);
    drive_item(swarq_pkg::KIND_SEND, 13'h1000, '1, '1, '1);
    repeat (6) drive_item(swarq_pkg::KIND_SEND, 13'($urandom), $urandom, $urandom, $urandom);
    drive_item(swarq_pkg::KIND_SEND, '0, '0, '0, '0);          // window full
    send_ack(sb.base_seq, 1'b1);                               // bad checksum
    send_ack(sb.next_seq, 1'b0);                               // past the window
    send_ack(sb.base_seq + 2, 1'b0);                           // hole, base holds
    send_ack(sb.base_seq, 1'b0);                               // base moves
    send_ack(sb.base_seq - 1, 1'b0);                           // behind base
    drive_item(KIND_NONE, 13'($urandom), $urandom, $urandom, $urandom);
    drive_item(swarq_pkg::KIND_TICK, '0, '0, '0, '0);          // counts down only
    drain();

    // window 0 acts as 1, timeout 0 acts as 1
    set_config(4'd0, 24'd0);
    send_ack(sb.base_seq, 1'b0);                               // restarts timer
    drive_item(swarq_pkg::KIND_TICK, '0, '0, '0, '0);          // resend of unacked packets
    drive_item(swarq_pkg::KIND_SEND, '0, '0, '0, '0);          // refused
    drive_item(swarq_pkg::KIND_TICK, '0, '0, '0, '0);
    while (sb.next_seq != sb.base_seq)
      send_ack(sb.base_seq + $urandom_range(sb.next_seq - sb.base_seq - 1), 1'b0);
    drive_item(swarq_pkg::KIND_SEND, 13'($urandom), '0, '0, '0);
    drive_item(swarq_pkg::KIND_TICK, '0, '0, '0, '0);
    send_ack(sb.base_seq, 1'b0);                               // window empties
    drive_item(swarq_pkg::KIND_TICK, '0, '0, '0, '0);
    drain();

    for (int i = 0; i < 8; i++) begin
      set_config(phase_win[i], phase_tmo[i]);
      idle_en = (i != 3);
      run_random(57);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
